FILE: rtl/core/bilinear_upsample_2x_macros.svh
// assertion helpers used by the top-level core file
`ifndef BILINEAR_UPSAMPLE_2X_MACROS_SVH
`define BILINEAR_UPSAMPLE_2X_MACROS_SVH

// same-cycle implication
`define BU2X_ASSERT_NOW(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define BU2X_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

FILE: rtl/core/bu2x_pkg.sv
package bu2x_pkg;

	// default plane limits
	localparam int DEF_MAX_HEIGHT = 64;
	localparam int DEF_MAX_WIDTH  = 64;

	// fraction bits of the interpolation weights
	localparam int FRAC_BITS = 16;

	// extent register reset value
	localparam logic [6:0] EXTENT_RESET = 7'd64;

	// operation codes
	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_QUERY = 1'b1;

	// register indexes
	localparam logic REG_INPUT_HEIGHT = 1'b0;
	localparam logic REG_INPUT_WIDTH  = 1'b1;

	// word fields carried alongside the divider stages
	typedef struct packed {
		logic        op;
		logic        err;
		logic [6:0]  row;
		logic [6:0]  col;
		logic [15:0] sample;
	} side_t;

endpackage

FILE: rtl/core/bu2x_ram.sv
module bu2x_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read, held while not enabled
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: rtl/core/bu2x_div.sv
module bu2x_div #(
	parameter int NW = 30,
	parameter int DW = 8,
	parameter int QW = 23
) (
	input  logic          clk,
	input  logic [QW-1:0] ld,
	input  logic [NW-1:0] num,
	input  logic [DW-1:0] den,
	output logic [QW-1:0] quot
);

	// one quotient bit per stage, restoring
	logic [DW-1:0] rem_q [QW];
	logic [QW-1:0] low_q [QW];
	logic [DW-1:0] den_q [QW];
	logic [QW-1:0] quo_q [QW];

	for (genvar k = 0; k < QW; k++) begin : g_stage
		logic [DW-1:0] r_in;
		logic [QW-1:0] l_in;
		logic [DW-1:0] d_in;
		logic [QW-1:0] q_in;
		logic [DW:0]   t;
		logic          fits;

		if (k == 0) begin : g_first
			// upper dividend bits stay below the divisor
			assign r_in = DW'(num >> QW);
			assign l_in = num[QW-1:0];
			assign d_in = den;
			assign q_in = '0;
		end else begin : g_next
			assign r_in = rem_q[k-1];
			assign l_in = low_q[k-1];
			assign d_in = den_q[k-1];
			assign q_in = quo_q[k-1];
		end

		assign t    = {r_in, l_in[QW-1]};
		assign fits = (t >= {1'b0, d_in});

		always_ff @(posedge clk) begin
			if (ld[k]) begin
				quo_q[k] <= {q_in[QW-2:0], fits};
			end
		end

		if (k < QW - 1) begin : g_carry
			always_ff @(posedge clk) begin
				if (ld[k]) begin
					rem_q[k] <= fits ? DW'(t - {1'b0, d_in}) : t[DW-1:0];
					low_q[k] <= {l_in[QW-2:0], 1'b0};
					den_q[k] <= d_in;
				end
			end
		end
	end

	assign quot = quo_q[QW-1];

endmodule

FILE: rtl/core/bilinear_upsample_2x.sv
// channel   | handshake            | payload
// ----------+----------------------+-------------------------------------
// in        | in_valid / in_ready  | operation, row, col, sample
// out       | out_valid / out_ready| pixel_value, range_error
// config    | write_enable         | reg_index, write_data
//
// one word accepted per cycle while in_ready is high; the coordinate
// divider pipeline computes one quotient bit per stage.
// the four neighbors come from four parity banks read together.
// reset clears control state only; the plane banks are not cleared.
// a stall on out_ready holds the last stage; bubbles upstream still fill.
`include "bilinear_upsample_2x_macros.svh"

module bilinear_upsample_2x #(
	parameter int MAX_HEIGHT = bu2x_pkg::DEF_MAX_HEIGHT,
	parameter int MAX_WIDTH  = bu2x_pkg::DEF_MAX_WIDTH
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        write_enable,
	input  logic        reg_index,
	input  logic [6:0]  write_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        operation,
	input  logic [6:0]  row,
	input  logic [6:0]  col,
	input  logic signed [15:0] sample,
	output logic        out_valid,
	input  logic        out_ready,
	output logic signed [15:0] pixel_value,
	output logic        range_error
);

	import bu2x_pkg::*;

	localparam int EH = $clog2(MAX_HEIGHT + 1);
	localparam int EW = $clog2(MAX_WIDTH + 1);
	localparam int EM = (EH > EW) ? EH : EW;
	localparam int DW = EM + 1;
	localparam int NW = 7 + EM + FRAC_BITS;
	localparam int QW = EM + FRAC_BITS;
	localparam int L  = QW + 6;
	localparam int HHALF  = (MAX_HEIGHT + 1) / 2;
	localparam int WHALF  = (MAX_WIDTH + 1) / 2;
	localparam int BDEPTH = HHALF * WHALF;
	localparam int AW = (BDEPTH > 1) ? $clog2(BDEPTH) : 1;
	localparam int S2 = QW + 1;

	// configuration registers
	logic [6:0] height_q, width_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= EXTENT_RESET;
			width_q  <= EXTENT_RESET;
		end else if (write_enable) begin
			unique case (reg_index)
				REG_INPUT_HEIGHT: height_q <= write_data;
				REG_INPUT_WIDTH:  width_q  <= write_data;
				default:          height_q <= height_q;
			endcase
		end
	end

	// effective extents
	logic [EM-1:0] h_eff, w_eff, hm1, wm1;

	always_comb begin
		if (height_q == 7'd0) h_eff = EM'(1);
		else if (int'(height_q) > MAX_HEIGHT) h_eff = EM'(MAX_HEIGHT);
		else h_eff = EM'(height_q);
		if (width_q == 7'd0) w_eff = EM'(1);
		else if (int'(width_q) > MAX_WIDTH) w_eff = EM'(MAX_WIDTH);
		else w_eff = EM'(width_q);
	end

	assign hm1 = h_eff - EM'(1);
	assign wm1 = w_eff - EM'(1);

	// stage occupancy and load chain
	logic [L-1:0] vld_q;
	logic [L:0]   ld;
	side_t        side_q [QW+1];

	assign ld[L] = out_ready;
	for (genvar i = 0; i < L; i++) begin : g_ld
		assign ld[i] = !vld_q[i] || ld[i+1];
	end

	assign in_ready  = ld[0];
	assign out_valid = vld_q[L-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			for (int i = 0; i < L; i++) begin
				if (ld[i]) begin
					if (i == 0) vld_q[i] <= in_valid;
					else if (i == S2) vld_q[i] <= vld_q[i-1] && (side_q[QW].op == OP_QUERY);
					else vld_q[i] <= vld_q[i-1];
				end
			end
		end
	end

	// s1: dividend and divisor of both coordinates
	logic [NW-1:0] num_y_s1, num_x_s1;
	logic [DW-1:0] den_y_s1, den_x_s1;
	logic          err_in;

	assign err_in = (int'(row) >= 2 * int'(h_eff)) || (int'(col) >= 2 * int'(w_eff));

	always_ff @(posedge clk) begin
		if (ld[0]) begin
			num_y_s1  <= (NW'(row) * NW'(hm1)) << FRAC_BITS;
			num_x_s1  <= (NW'(col) * NW'(wm1)) << FRAC_BITS;
			den_y_s1  <= {h_eff, 1'b0} - DW'(1);
			den_x_s1  <= {w_eff, 1'b0} - DW'(1);
			side_q[0] <= '{op: operation, err: err_in, row: row, col: col, sample: sample};
		end
	end

	// sideband follows the divider stages
	always_ff @(posedge clk) begin
		for (int k = 1; k <= QW; k++) begin
			if (ld[k]) begin
				side_q[k] <= side_q[k-1];
			end
		end
	end

	// coordinate dividers
	logic [QW-1:0] qy, qx;

	bu2x_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_y (
		.clk(clk), .ld(ld[QW:1]), .num(num_y_s1), .den(den_y_s1), .quot(qy)
	);

	bu2x_div #(.NW(NW), .DW(DW), .QW(QW)) u_div_x (
		.clk(clk), .ld(ld[QW:1]), .num(num_x_s1), .den(den_x_s1), .quot(qx)
	);

	// neighbor coordinates and bank addresses
	logic [EM-1:0] y0, x0, y1, x1;
	logic          ys, xs;
	logic [EM-1:0] rsel [2];
	logic [EM-1:0] csel [2];

	assign y0 = qy[QW-1:FRAC_BITS];
	assign x0 = qx[QW-1:FRAC_BITS];
	assign ys = (y0 < hm1);
	assign xs = (x0 < wm1);
	assign y1 = y0 + EM'(ys);
	assign x1 = x0 + EM'(xs);

	always_comb begin
		for (int p = 0; p < 2; p++) begin
			rsel[p] = (y0[0] == p[0]) ? y0 : y1;
			csel[p] = (x0[0] == p[0]) ? x0 : x1;
		end
	end

	// load write into the parity bank
	side_t         ld_item;
	logic          wr_ok;
	logic [AW-1:0] waddr;

	assign ld_item = side_q[QW];
	assign wr_ok   = ld[S2] && vld_q[QW] && (ld_item.op == OP_LOAD)
		&& (int'(ld_item.row) < MAX_HEIGHT) && (int'(ld_item.col) < MAX_WIDTH);
	assign waddr   = AW'((int'(ld_item.row) >> 1) * WHALF + (int'(ld_item.col) >> 1));

	logic [15:0] rd [4];

	for (genvar b = 0; b < 4; b++) begin : g_bank
		logic [AW-1:0] raddr;
		logic          we;

		assign raddr = AW'((int'(rsel[b/2]) >> 1) * WHALF + (int'(csel[b%2]) >> 1));
		assign we    = wr_ok && (ld_item.row[0] == 1'(b / 2)) && (ld_item.col[0] == 1'(b % 2));

		bu2x_ram #(.WIDTH(16), .DEPTH(BDEPTH)) u_ram (
			.clk(clk), .we(we), .waddr(waddr), .wdata(ld_item.sample),
			.re(ld[S2]), .raddr(raddr), .rdata(rd[b])
		);
	end

	// s2: weights and bank selects beside the read data
	logic [15:0] fy_s2, fx_s2;
	logic        yp_s2, xp_s2, ys_s2, xs_s2, err_s2;

	always_ff @(posedge clk) begin
		if (ld[S2]) begin
			fy_s2  <= qy[FRAC_BITS-1:0];
			fx_s2  <= qx[FRAC_BITS-1:0];
			yp_s2  <= y0[0];
			xp_s2  <= x0[0];
			ys_s2  <= ys;
			xs_s2  <= xs;
			err_s2 <= ld_item.err;
		end
	end

	// s3: column weights times samples
	logic signed [15:0] sa, sb, sc, sd;
	logic [16:0]        wx0;
	logic signed [33:0] pa_s3, pb_s3, pc_s3, pd_s3;
	logic [15:0]        fy_s3;
	logic               err_s3;

	assign sa  = $signed(rd[{yp_s2, xp_s2}]);
	assign sb  = $signed(rd[{yp_s2, xp_s2 ^ xs_s2}]);
	assign sc  = $signed(rd[{yp_s2 ^ ys_s2, xp_s2}]);
	assign sd  = $signed(rd[{yp_s2 ^ ys_s2, xp_s2 ^ xs_s2}]);
	assign wx0 = 17'h10000 - {1'b0, fx_s2};

	always_ff @(posedge clk) begin
		if (ld[S2+1]) begin
			pa_s3  <= $signed({1'b0, wx0}) * sa;
			pb_s3  <= $signed({2'b00, fx_s2}) * sb;
			pc_s3  <= $signed({1'b0, wx0}) * sc;
			pd_s3  <= $signed({2'b00, fx_s2}) * sd;
			fy_s3  <= fy_s2;
			err_s3 <= err_s2;
		end
	end

	// s4: row sums
	logic signed [34:0] top_s4, bot_s4;
	logic [15:0]        fy_s4;
	logic               err_s4;

	always_ff @(posedge clk) begin
		if (ld[S2+2]) begin
			top_s4 <= 35'(pa_s3) + 35'(pb_s3);
			bot_s4 <= 35'(pc_s3) + 35'(pd_s3);
			fy_s4  <= fy_s3;
			err_s4 <= err_s3;
		end
	end

	// s5: row weights
	logic [16:0]        wy0;
	logic signed [52:0] mt_s5, mb_s5;
	logic               err_s5;

	assign wy0 = 17'h10000 - {1'b0, fy_s4};

	always_ff @(posedge clk) begin
		if (ld[S2+3]) begin
			mt_s5  <= $signed({1'b0, wy0}) * top_s4;
			mb_s5  <= $signed({2'b00, fy_s4}) * bot_s4;
			err_s5 <= err_s4;
		end
	end

	// s6: blend, round half up, output word
	logic signed [53:0] blend;
	logic signed [15:0] pixel_q;
	logic               err_q;

	assign blend = 54'(mt_s5) + 54'(mb_s5) + 54'(64'sd2147483648);

	always_ff @(posedge clk) begin
		if (ld[S2+4]) begin
			pixel_q <= err_s5 ? 16'sd0 : $signed(blend[47:32]);
			err_q   <= err_s5;
		end
	end

	assign pixel_value = pixel_q;
	assign range_error = err_q;

	`BU2X_ASSERT_NOW(a_err_zero, clk, arst_n, out_valid && range_error, pixel_value == 16'sd0)
	`BU2X_ASSERT_NOW(a_full_stall, clk, arst_n, !in_ready, (&vld_q) && !out_ready)
	`BU2X_ASSERT_NEXT(a_load_drops, clk, arst_n,
		ld[S2] && vld_q[QW] && (side_q[QW].op == OP_LOAD), !vld_q[S2])

endmodule
